>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl modules
// both expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/qkvhs_pkg.sv
package qkvhs_pkg;

    // field and datapath widths
    localparam int OFFS_W     = 20;
    localparam int UNIT_W     = 21;
    localparam int HG_W       = 8;
    localparam int RW_W       = 12;
    localparam int GQ_W       = 18;
    localparam int GKV_W      = 13;
    localparam int QKV_W      = 19;
    localparam int TILE_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    // divider layout: quotient bits resolved per stage, stage count
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES         = UNIT_W / DIV_BITS_PER_STAGE;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_Q_HEADS_PER_KV  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_KV_HEADS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIM_TILES  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH_TILES = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_TILES       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_GROUPS     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS_PER_GROUP = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_START      = 4'd7;

    typedef enum logic [1:0] {
        CHUNK_Q = 2'd0,
        CHUNK_K = 2'd1,
        CHUNK_V = 2'd2
    } chunk_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [OFFS_W-1:0] unit_start;
        logic [HG_W-1:0]   hg;
        logic [RW_W-1:0]   rw;
        logic [GQ_W-1:0]   grp_q;
        logic [GKV_W-1:0]  grp_kv;
        logic [GQ_W-1:0]   q_total;
        logic [QKV_W-1:0]  qkv_total;
        logic              ne_q;
        logic              ne_kv;
    } cfg_t;

    // chunk start tiles of one work unit
    typedef struct packed {
        logic [TILE_W-1:0] start_q;
        logic [TILE_W-1:0] start_k;
        logic [TILE_W-1:0] start_v;
    } job_t;

endpackage

>>> hdl/qkvhs_cfg.sv
module qkvhs_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qkvhs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qkvhs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output qkvhs_pkg::cfg_t                      cfg
);

    logic [4:0]                       qh_reg;
    logic [7:0]                       nkv_reg;
    logic [4:0]                       hd_reg;
    logic [qkvhs_pkg::RW_W-1:0]       rw_reg;
    logic [qkvhs_pkg::HG_W-1:0]       hg_reg;
    logic [7:0]                       hpg_reg;
    logic [qkvhs_pkg::OFFS_W-1:0]     us_reg;

    logic [qkvhs_pkg::GKV_W-1:0]      hq_reg;
    logic [qkvhs_pkg::GKV_W-1:0]      nq_reg;
    logic [qkvhs_pkg::GKV_W-1:0]      grp_kv_reg;
    logic [qkvhs_pkg::GKV_W-1:0]      kv_total_reg;
    logic [qkvhs_pkg::GQ_W-1:0]       grp_q_reg;
    logic [qkvhs_pkg::GQ_W-1:0]       q_total_reg;
    logic [qkvhs_pkg::QKV_W-1:0]      qkv_total_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qh_reg  <= 5'd1;
            nkv_reg <= 8'd16;
            hd_reg  <= 5'd2;
            rw_reg  <= 12'd96;
            hg_reg  <= 8'd16;
            hpg_reg <= 8'd1;
            us_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qkvhs_pkg::CFG_Q_HEADS_PER_KV:  qh_reg  <= cfg_data[4:0];
                qkvhs_pkg::CFG_NUM_KV_HEADS:    nkv_reg <= cfg_data[7:0];
                qkvhs_pkg::CFG_HEAD_DIM_TILES:  hd_reg  <= cfg_data[4:0];
                qkvhs_pkg::CFG_ROW_WIDTH_TILES: rw_reg  <= cfg_data[11:0];
                // base tile is block * row width, so the split by seq tiles drops out
                qkvhs_pkg::CFG_SEQ_TILES:       ;
                qkvhs_pkg::CFG_HEAD_GROUPS:     hg_reg  <= cfg_data[7:0];
                qkvhs_pkg::CFG_HEADS_PER_GROUP: hpg_reg <= cfg_data[7:0];
                qkvhs_pkg::CFG_UNIT_START:      us_reg  <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // derived products, registered from the config registers behind a write
    always_ff @(posedge clk)
    begin
        hq_reg        <= qkvhs_pkg::GKV_W'(hpg_reg) * qkvhs_pkg::GKV_W'(qh_reg);
        nq_reg        <= qkvhs_pkg::GKV_W'(nkv_reg) * qkvhs_pkg::GKV_W'(qh_reg);
        grp_kv_reg    <= qkvhs_pkg::GKV_W'(hpg_reg) * qkvhs_pkg::GKV_W'(hd_reg);
        kv_total_reg  <= qkvhs_pkg::GKV_W'(nkv_reg) * qkvhs_pkg::GKV_W'(hd_reg);
        grp_q_reg     <= qkvhs_pkg::GQ_W'(hq_reg) * qkvhs_pkg::GQ_W'(hd_reg);
        q_total_reg   <= qkvhs_pkg::GQ_W'(nq_reg) * qkvhs_pkg::GQ_W'(hd_reg);
        qkv_total_reg <= qkvhs_pkg::QKV_W'(q_total_reg) + qkvhs_pkg::QKV_W'(kv_total_reg);
    end

    always_comb
    begin
        cfg.unit_start = us_reg;
        cfg.hg         = (hg_reg == '0) ? qkvhs_pkg::HG_W'(1) : hg_reg;
        cfg.rw         = rw_reg;
        cfg.grp_q      = grp_q_reg;
        cfg.grp_kv     = grp_kv_reg;
        cfg.q_total    = q_total_reg;
        cfg.qkv_total  = qkv_total_reg;
        cfg.ne_q       = (grp_q_reg != '0);
        cfg.ne_kv      = (grp_kv_reg != '0);
    end

endmodule

>>> hdl/qkvhs_div.sv
`include "assert_macros.svh"

module qkvhs_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic [qkvhs_pkg::HG_W-1:0]         hg,
    input  logic                               in_valid,
    input  logic [qkvhs_pkg::UNIT_W-1:0]       dividend,
    output logic                               out_valid,
    output logic [qkvhs_pkg::UNIT_W-1:0]       quot,
    output logic [qkvhs_pkg::HG_W-1:0]         rem
);

    localparam int NS  = qkvhs_pkg::DIV_STAGES;
    localparam int BPS = qkvhs_pkg::DIV_BITS_PER_STAGE;
    localparam int UW  = qkvhs_pkg::UNIT_W;
    localparam int RW  = qkvhs_pkg::HG_W;

    // work word holds the unconsumed dividend bits on top, quotient bits below
    logic [NS-1:0] v_reg;
    logic [UW-1:0] w_reg  [NS];
    logic [RW-1:0] r_reg  [NS];
    logic [UW-1:0] w_next [NS];
    logic [RW-1:0] r_next [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [UW-1:0] w_in;
        logic [RW-1:0] r_in;

        if (s == 0)
        begin : g_first
            assign w_in = dividend;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign w_in = w_reg[s-1];
            assign r_in = r_reg[s-1];
        end

        // restoring steps, one quotient bit each
        always_comb
        begin
            logic [RW:0]   t;
            logic [RW-1:0] r;
            logic [UW-1:0] w;
            r = r_in;
            w = w_in;
            for (int b = 0; b < BPS; b++)
            begin
                t = {r, w[UW-1]};
                if (t >= {1'b0, hg})
                begin
                    t = t - {1'b0, hg};
                    w = {w[UW-2:0], 1'b1};
                end
                else
                begin
                    w = {w[UW-2:0], 1'b0};
                end
                r = t[RW-1:0];
            end
            w_next[s] = w;
            r_next[s] = r;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg[s] <= w_next[s];
                r_reg[s] <= r_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[NS-1];
    assign quot      = w_reg[NS-1];
    assign rem       = r_reg[NS-1];

    `ASSERT_CLK(a_rem_below_divisor, v_reg[NS-1] |-> (r_reg[NS-1] < hg),
        "divider remainder not below the group count")

endmodule

>>> hdl/qkvhs_addr.sv
module qkvhs_addr (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  qkvhs_pkg::cfg_t                    cfg,
    input  logic                               in_valid,
    input  logic [qkvhs_pkg::UNIT_W-1:0]       block,
    input  logic [qkvhs_pkg::HG_W-1:0]         group,
    output logic                               out_valid,
    output qkvhs_pkg::job_t                    job
);

    localparam int TW  = qkvhs_pkg::TILE_W;
    localparam int BPW = qkvhs_pkg::UNIT_W + qkvhs_pkg::RW_W;
    localparam int GQW = qkvhs_pkg::HG_W + qkvhs_pkg::GQ_W;
    localparam int GKW = qkvhs_pkg::HG_W + qkvhs_pkg::GKV_W;

    logic [2:0]     v_reg;
    logic [BPW-1:0] base_prod;
    logic [GQW-1:0] gq_prod;
    logic [GKW-1:0] gk_prod;
    logic [TW-1:0]  base_reg;
    logic [GQW-1:0] gq_reg;
    logic [GKW-1:0] gk_reg;
    logic [TW-1:0]  s0_reg;
    logic [TW-1:0]  b1_reg;
    logic [TW-1:0]  q_reg;
    logic [TW-1:0]  k_reg;
    logic [TW-1:0]  vv_reg;

    assign base_prod = BPW'(block) * BPW'(cfg.rw);
    assign gq_prod   = GQW'(group) * GQW'(cfg.grp_q);
    assign gk_prod   = GKW'(group) * GKW'(cfg.grp_kv);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products
            base_reg <= base_prod[TW-1:0];
            gq_reg   <= gq_prod;
            gk_reg   <= gk_prod;
            // group offsets onto the row base
            s0_reg   <= base_reg + TW'(gq_reg);
            b1_reg   <= base_reg + TW'(gk_reg);
            // skip past the q and k sections of the fused row
            q_reg    <= s0_reg;
            k_reg    <= b1_reg + TW'(cfg.q_total);
            vv_reg   <= b1_reg + TW'(cfg.qkv_total);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_valid   = v_reg[2];
    assign job.start_q = q_reg;
    assign job.start_k = k_reg;
    assign job.start_v = vv_reg;

endmodule

>>> hdl/qkvhs_emit.sv
`include "assert_macros.svh"

module qkvhs_emit #(
    parameter int MAX_TILES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qkvhs_pkg::cfg_t                    cfg,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  qkvhs_pkg::job_t                    job,
    output logic                               tile_valid,
    input  logic                               tile_ready,
    output logic [qkvhs_pkg::TILE_W-1:0]       tile_index,
    output logic [1:0]                         chunk,
    output logic                               chunk_end,
    output logic                               last
);

    localparam int CW = $clog2(MAX_TILES);
    localparam int TW = qkvhs_pkg::TILE_W;
    localparam int LW = qkvhs_pkg::GQ_W;

    logic                  act_reg,  act_next;
    qkvhs_pkg::chunk_t     c_reg,    c_next;
    logic [CW-1:0]         i_reg,    i_next;
    logic [CW-1:0]         n_reg,    n_next;
    qkvhs_pkg::job_t       job_reg;
    logic                  tv_reg,   tv_next;
    logic [TW-1:0]         tile_reg;
    qkvhs_pkg::chunk_t     chunk_reg;
    logic                  ce_reg;
    logic                  last_reg;

    logic                  adv;
    logic                  step;
    logic                  load;
    logic                  free;
    logic [LW-1:0]         len_c;
    logic [TW-1:0]         start_c;
    logic                  ce;
    logic                  trunc;
    logic                  has_next;
    logic                  fin;
    qkvhs_pkg::chunk_t     c_after;

    assign adv  = !tv_reg || tile_ready;
    assign step = adv && act_reg;
    assign free = !act_reg || (step && fin);
    assign load = job_valid && free;
    assign job_ready = free;

    // current tile decode
    always_comb
    begin
        case (c_reg)
            qkvhs_pkg::CHUNK_Q:
            begin
                len_c    = cfg.grp_q;
                start_c  = job_reg.start_q;
                has_next = cfg.ne_kv;
                c_after  = qkvhs_pkg::CHUNK_K;
            end
            qkvhs_pkg::CHUNK_K:
            begin
                len_c    = LW'(cfg.grp_kv);
                start_c  = job_reg.start_k;
                has_next = 1'b1;
                c_after  = qkvhs_pkg::CHUNK_V;
            end
            default:
            begin
                len_c    = LW'(cfg.grp_kv);
                start_c  = job_reg.start_v;
                has_next = 1'b0;
                c_after  = qkvhs_pkg::CHUNK_V;
            end
        endcase
        ce    = ((LW'(i_reg) + LW'(1)) == len_c);
        trunc = (n_reg == CW'(MAX_TILES - 1));
        fin   = trunc || (ce && !has_next);
    end

    // walk state
    always_comb
    begin
        act_next = act_reg;
        c_next   = c_reg;
        i_next   = i_reg;
        n_next   = n_reg;
        if (step)
        begin
            if (fin)
            begin
                act_next = 1'b0;
            end
            else if (ce)
            begin
                c_next = c_after;
                i_next = '0;
                n_next = n_reg + CW'(1);
            end
            else
            begin
                i_next = i_reg + CW'(1);
                n_next = n_reg + CW'(1);
            end
        end
        if (load)
        begin
            // a unit with every chunk empty gives nothing
            act_next = cfg.ne_q || cfg.ne_kv;
            c_next   = cfg.ne_q ? qkvhs_pkg::CHUNK_Q : qkvhs_pkg::CHUNK_K;
            i_next   = '0;
            n_next   = '0;
        end
        tv_next = adv ? act_reg : tv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            c_reg   <= qkvhs_pkg::CHUNK_Q;
            i_reg   <= '0;
            n_reg   <= '0;
            tv_reg  <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            c_reg   <= c_next;
            i_reg   <= i_next;
            n_reg   <= n_next;
            tv_reg  <= tv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
        if (step)
        begin
            tile_reg  <= start_c + TW'(i_reg);
            chunk_reg <= c_reg;
            ce_reg    <= ce || fin;
            last_reg  <= fin;
        end
    end

    assign tile_valid = tv_reg;
    assign tile_index = tile_reg;
    assign chunk      = chunk_reg;
    assign chunk_end  = ce_reg;
    assign last       = last_reg;

    `ASSERT_CLK(a_tile_within_count, act_reg |-> (i_reg <= n_reg),
        "tile index in chunk runs ahead of emitted count")
    `ASSERT_CLK(a_unit_continues, (step && !fin) |=> act_reg,
        "unit dropped before its last tile")
    `ASSERT_NEVER(a_empty_q_walked, act_reg && c_reg == qkvhs_pkg::CHUNK_Q && !cfg.ne_q,
        "walking an empty query chunk")

endmodule

>>> hdl/qkv_head_split_tile_address_gen_core.sv
// channel | dir | handshake               | payload
// unit    | in  | unit_valid / unit_ready | unit_offset[19:0]
// tile    | out | tile_valid / tile_ready | tile_index[31:0], chunk[1:0], chunk_end, last
// cfg     | in  | cfg_valid / cfg_ready   | cfg_index[3:0], cfg_data[19:0]
//
// the accepting edge loads the entry stage; tile_valid rises once the unit has passed:
// 7 divider stages (3 quotient bits each), 3 address stages, 1 walker load, 1 output
// each unit then gives min(Q + 2*KV tiles, MAX_TILES_PER_UNIT) tiles, one tile a cycle
// while tile_ready holds, or no tile if every chunk is empty
// reset is asynchronous: config registers take their defaults, pipeline empties
// tile_ready low freezes the output register and walker; the pipe stalls behind them
module qkv_head_split_tile_address_gen_core #(
    parameter int MAX_TILES_PER_UNIT = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // work unit requests
    input  logic                                 unit_valid,
    output logic                                 unit_ready,
    input  logic [qkvhs_pkg::OFFS_W-1:0]         unit_offset,
    // tile requests out
    output logic                                 tile_valid,
    input  logic                                 tile_ready,
    output logic [qkvhs_pkg::TILE_W-1:0]         tile_index,
    output logic [1:0]                           chunk,
    output logic                                 chunk_end,
    output logic                                 last,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qkvhs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qkvhs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    qkvhs_pkg::cfg_t                     cfg;

    // pipe advance: everything moves when the walker can take the next unit
    logic                                pipe_en;
    logic                                unit_v_reg;
    logic [qkvhs_pkg::UNIT_W-1:0]        unit_reg;

    logic                                div_valid;
    logic [qkvhs_pkg::UNIT_W-1:0]        block;
    logic [qkvhs_pkg::HG_W-1:0]          group;

    logic                                job_valid;
    logic                                job_ready;
    qkvhs_pkg::job_t                     job;

    qkvhs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign pipe_en    = !job_valid || job_ready;
    assign unit_ready = pipe_en;

    // entry stage: global unit index, 21 bits so the sum never wraps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            unit_v_reg <= unit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            unit_reg <= qkvhs_pkg::UNIT_W'(cfg.unit_start)
                      + qkvhs_pkg::UNIT_W'(unit_offset);
        end
    end

    // block = unit / group count, group = remainder of that division
    qkvhs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .hg        (cfg.hg),
        .in_valid  (unit_v_reg),
        .dividend  (unit_reg),
        .out_valid (div_valid),
        .quot      (block),
        .rem       (group)
    );

    // row base is block * row width (batch and seq tile recombine to block),
    // then q, k and v chunk starts for the group
    qkvhs_addr u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .block     (block),
        .group     (group),
        .out_valid (job_valid),
        .job       (job)
    );

    // tile walker with registered output
    qkvhs_emit #(
        .MAX_TILES (MAX_TILES_PER_UNIT)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .tile_valid (tile_valid),
        .tile_ready (tile_ready),
        .tile_index (tile_index),
        .chunk      (chunk),
        .chunk_end  (chunk_end),
        .last       (last)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // tile cap handed to the block, also used by the tile planner
    localparam int TILE_CAP = 64;
    // quiet cycles (no request on any channel) before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // wait after the last tile so units with no tiles clear the pipe; pad generously
    localparam int SETTLE_CYCLES = 40;
    // index past the last register, writes there are dropped by the block
    localparam logic [qkvhs_pkg::CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 4'd15;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int UNITS_PER_SEGMENT = 55;

    // one tile request as the block should emit it
    typedef struct packed {
        logic [qkvhs_pkg::TILE_W-1:0] tile_index;
        qkvhs_pkg::chunk_t            chunk;
        logic                         chunk_end;
        logic                         last;
    } tile_rec_t;

    // keeps a copy of the registers, turns each work unit into its tile list
    // and checks the tile stream in order against it
    class tile_scoreboard;
        longint unsigned regs [8];
        tile_rec_t       tiles_due [$];
        int              mismatches;
        int              tiles_checked;
        int              units_planned;

        function new();
            regs[qkvhs_pkg::CFG_Q_HEADS_PER_KV]  = 1;
            regs[qkvhs_pkg::CFG_NUM_KV_HEADS]    = 16;
            regs[qkvhs_pkg::CFG_HEAD_DIM_TILES]  = 2;
            regs[qkvhs_pkg::CFG_ROW_WIDTH_TILES] = 96;
            regs[qkvhs_pkg::CFG_SEQ_TILES]       = 16;
            regs[qkvhs_pkg::CFG_HEAD_GROUPS]     = 16;
            regs[qkvhs_pkg::CFG_HEADS_PER_GROUP] = 1;
            regs[qkvhs_pkg::CFG_UNIT_START]      = 0;
            mismatches    = 0;
            tiles_checked = 0;
            units_planned = 0;
        endfunction

        // registers keep only their own width
        function void write_reg(logic [qkvhs_pkg::CFG_IDX_W-1:0] idx,
                                logic [qkvhs_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                qkvhs_pkg::CFG_Q_HEADS_PER_KV, qkvhs_pkg::CFG_HEAD_DIM_TILES:
                    regs[idx] = 64'(data[4:0]);
                qkvhs_pkg::CFG_NUM_KV_HEADS, qkvhs_pkg::CFG_HEAD_GROUPS,
                qkvhs_pkg::CFG_HEADS_PER_GROUP:
                    regs[idx] = 64'(data[7:0]);
                qkvhs_pkg::CFG_ROW_WIDTH_TILES:
                    regs[idx] = 64'(data[11:0]);
                qkvhs_pkg::CFG_SEQ_TILES:
                    regs[idx] = 64'(data[12:0]);
                qkvhs_pkg::CFG_UNIT_START:
                    regs[idx] = 64'(data);
                default: ;
            endcase
        endfunction

        // split the unit into group / sequence tile / batch and list its q, k, v tiles
        function void plan_unit_tiles(logic [qkvhs_pkg::OFFS_W-1:0] offset);
            longint unsigned hg, st, rw, unit, blk, grp, s_tile, batch, total, i;
            logic [qkvhs_pkg::TILE_W-1:0] base, grp_q, grp_kv, q_total, kv_total, g;
            logic [qkvhs_pkg::TILE_W-1:0] first_tile [3];
            logic [qkvhs_pkg::TILE_W-1:0] run_len [3];
            tile_rec_t rec;
            int n, c;

            // zero divisors behave as one
            hg = (regs[qkvhs_pkg::CFG_HEAD_GROUPS] != 0) ? regs[qkvhs_pkg::CFG_HEAD_GROUPS] : 1;
            st = (regs[qkvhs_pkg::CFG_SEQ_TILES] != 0) ? regs[qkvhs_pkg::CFG_SEQ_TILES] : 1;
            rw = regs[qkvhs_pkg::CFG_ROW_WIDTH_TILES];
            unit = regs[qkvhs_pkg::CFG_UNIT_START] + 64'(offset);
            blk = unit / hg;
            grp = unit - blk * hg;
            s_tile = blk % st;
            batch = blk / st;
            base = qkvhs_pkg::TILE_W'(batch * st * rw + s_tile * rw);
            grp_q = qkvhs_pkg::TILE_W'(regs[qkvhs_pkg::CFG_HEADS_PER_GROUP]
                                       * regs[qkvhs_pkg::CFG_Q_HEADS_PER_KV]
                                       * regs[qkvhs_pkg::CFG_HEAD_DIM_TILES]);
            grp_kv = qkvhs_pkg::TILE_W'(regs[qkvhs_pkg::CFG_HEADS_PER_GROUP]
                                        * regs[qkvhs_pkg::CFG_HEAD_DIM_TILES]);
            q_total = qkvhs_pkg::TILE_W'(regs[qkvhs_pkg::CFG_NUM_KV_HEADS]
                                         * regs[qkvhs_pkg::CFG_Q_HEADS_PER_KV]
                                         * regs[qkvhs_pkg::CFG_HEAD_DIM_TILES]);
            kv_total = qkvhs_pkg::TILE_W'(regs[qkvhs_pkg::CFG_NUM_KV_HEADS]
                                          * regs[qkvhs_pkg::CFG_HEAD_DIM_TILES]);
            g = qkvhs_pkg::TILE_W'(grp);

            // everything wraps at 32 bits
            first_tile[0] = base + g * grp_q;
            first_tile[1] = base + q_total + g * grp_kv;
            first_tile[2] = base + q_total + kv_total + g * grp_kv;
            run_len[0] = grp_q;
            run_len[1] = grp_kv;
            run_len[2] = grp_kv;

            n = 0;
            for (c = 0; c < 3 && n < TILE_CAP; c++)
            begin
                for (i = 0; i < run_len[c] && n < TILE_CAP; i++)
                begin
                    rec.tile_index = first_tile[c] + qkvhs_pkg::TILE_W'(i);
                    rec.chunk = qkvhs_pkg::chunk_t'(c);
                    rec.chunk_end = (i + 1 == run_len[c]);
                    rec.last = 1'b0;
                    tiles_due.push_back(rec);
                    n++;
                end
            end

            // last tile flagged; a truncated run also closes its chunk
            if (n > 0)
            begin
                total = longint'(run_len[0]) + run_len[1] + run_len[2];
                rec = tiles_due[tiles_due.size() - 1];
                rec.last = 1'b1;
                if (total > 64'(n))
                    rec.chunk_end = 1'b1;
                tiles_due[tiles_due.size() - 1] = rec;
            end
            units_planned++;
        endfunction

        function void check_tile(logic [qkvhs_pkg::TILE_W-1:0] idx, logic [1:0] ch,
                                 logic ce, logic lst);
            tile_rec_t want;
            tiles_checked++;
            if (tiles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected tile idx=%0d chunk=%0d end=%0b last=%0b",
                             $realtime, idx, ch, ce, lst);
                return;
            end
            want = tiles_due.pop_front();
            if (want.tile_index !== idx || want.chunk !== ch
                || want.chunk_end !== ce || want.last !== lst)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: tile mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                             $realtime, want.tile_index, want.chunk, want.chunk_end,
                             want.last, idx, ch, ce, lst);
            end
        endfunction

        function int pending();
            return tiles_due.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               unit_valid = 1'b0;
    logic                               unit_ready;
    logic [qkvhs_pkg::OFFS_W-1:0]       unit_offset = '0;
    logic                               tile_valid;
    logic                               tile_ready = 1'b0;
    logic [qkvhs_pkg::TILE_W-1:0]       tile_index;
    logic [1:0]                         chunk;
    logic                               chunk_end;
    logic                               last;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [qkvhs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [qkvhs_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    tile_scoreboard sb = new();

    // idle rates in percent, changed between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          quiet_cycles = 0;
    int          settings_used = 0;

    qkv_head_split_tile_address_gen_core #(
        .MAX_TILES_PER_UNIT(TILE_CAP)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_offset(unit_offset),
        .tile_valid (tile_valid),
        .tile_ready (tile_ready),
        .tile_index (tile_index),
        .chunk      (chunk),
        .chunk_end  (chunk_end),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: ready drops at random with the current stall rate
    always @(posedge clk)
    begin
        tile_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every accepted tile request goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && tile_valid && tile_ready)
            sb.check_tile(tile_index, chunk, chunk_end, last);
    end

    // hang detection: any request on any channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (unit_valid && unit_ready) || (tile_valid && tile_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles, %0d tiles still due",
                     quiet_cycles, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one register write; valid stays up so writes can run back to back
    task automatic cfg_write(input logic [qkvhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qkvhs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // full register set in index order, then release the write channel
    task automatic program_regs(input logic [qkvhs_pkg::CFG_DATA_W-1:0] q_per_kv, kv_heads,
                                dim_tiles, row_tiles, seq, groups, heads_in_group, start);
        cfg_write(qkvhs_pkg::CFG_Q_HEADS_PER_KV, q_per_kv);
        cfg_write(qkvhs_pkg::CFG_NUM_KV_HEADS, kv_heads);
        cfg_write(qkvhs_pkg::CFG_HEAD_DIM_TILES, dim_tiles);
        cfg_write(qkvhs_pkg::CFG_ROW_WIDTH_TILES, row_tiles);
        cfg_write(qkvhs_pkg::CFG_SEQ_TILES, seq);
        cfg_write(qkvhs_pkg::CFG_HEAD_GROUPS, groups);
        cfg_write(qkvhs_pkg::CFG_HEADS_PER_GROUP, heads_in_group);
        cfg_write(qkvhs_pkg::CFG_UNIT_START, start);
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // work unit request; valid only drops when the sender decides to idle,
    // so consecutive requests never lower and raise it in the same step
    task automatic push_unit(input logic [qkvhs_pkg::OFFS_W-1:0] offset);
        if ($urandom_range(99) < send_idle_pct)
        begin
            unit_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit_offset <= offset;
        @(posedge clk);
        while (!unit_ready)
            @(posedge clk);
        sb.plan_unit_tiles(offset);
    endtask

    // drop valid, wait for every tile, then let units with no tiles clear the pipe
    task automatic drain_units();
        unit_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // mostly moderate values, sometimes the range ends
    function automatic logic [qkvhs_pkg::CFG_DATA_W-1:0] pick_reg(int unsigned lo,
                                                                   int unsigned hi,
                                                                   int unsigned typical_hi);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return qkvhs_pkg::CFG_DATA_W'(lo);
        else if (r == 1)
            return qkvhs_pkg::CFG_DATA_W'(hi);
        return qkvhs_pkg::CFG_DATA_W'($urandom_range(typical_hi, lo));
    endfunction

    // mix of small offsets (neighboring groups and tiles) and full-width ones
    function automatic logic [qkvhs_pkg::OFFS_W-1:0] pick_offset();
        if ($urandom_range(3) == 0)
            return qkvhs_pkg::OFFS_W'($urandom());
        return qkvhs_pkg::OFFS_W'($urandom_range(1023));
    endfunction

    initial
    begin
        int seg, k;

        // hold reset low, then release it
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults out of reset: six tiles a unit
        push_unit('0);
        push_unit(20'd1);
        push_unit(20'd16);
        push_unit(20'hFFFFF);
        push_unit(20'h55555);
        drain_units();

        // large values in every register: q chunk alone overflows, run cut at the cap
        program_regs(20'd16, 20'd128, 20'd16, 20'd4095, 20'd4096, 20'd128, 20'd128, 20'hFFFFF);
        push_unit('0);
        push_unit(20'hFFFFF);
        drain_units();

        // one group, one sequence tile, wide rows: base tile wraps past 32 bits
        program_regs(20'd1, 20'd1, 20'd1, 20'd4095, 20'd1, 20'd1, 20'd1, 20'hFFFFF);
        push_unit(20'hFFFFF);
        push_unit(20'h80000);
        drain_units();

        // group count and sequence length written with only upper bits set: both mask to zero
        program_regs(20'd2, 20'd4, 20'd3, 20'd7, 20'hFE000, 20'hFFF00, 20'd2, 20'd5);
        push_unit(20'd3);
        push_unit(20'hFFFFF);
        drain_units();

        // write to an unmapped index must not disturb anything
        cfg_write(CFG_IDX_UNMAPPED, 20'hFFFFF);
        // no heads per group: every chunk empty, units produce no tiles
        program_regs(20'd1, 20'd16, 20'd2, 20'd96, 20'd16, 20'd16, 20'd0, 20'd0);
        push_unit('0);
        push_unit(20'd7);
        drain_units();

        // no query heads: q chunk empty, k and v still emitted
        program_regs(20'd0, 20'd5, 20'd2, 20'd10, 20'd3, 20'd4, 20'd3, 20'd0);
        push_unit(20'd1);
        push_unit(20'd2);
        drain_units();

        // smallest sizes: one tile per chunk
        program_regs(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd0);
        push_unit('0);
        push_unit(20'd1);
        push_unit(20'd2);
        drain_units();

        // exactly the cap: 32 q + 16 k + 16 v, nothing cut
        program_regs(20'd2, 20'd2, 20'd16, 20'd100, 20'd4, 20'd2, 20'd1, 20'd0);
        push_unit('0);
        push_unit(20'd3);
        drain_units();

        // one past the cap: last v tile dropped, previous one closes the chunk
        program_regs(20'd3, 20'd4, 20'd13, 20'd200, 20'd8, 20'd2, 20'd1, 20'd0);
        push_unit('0);
        push_unit(20'd1);
        drain_units();

        // random settings, cycling through the idle mixes
        for (seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            case (seg % 4)
                1: send_idle_pct = 61;
                2: recv_stall_pct = 61;
                3:
                begin
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
                default: ;
            endcase
            program_regs(pick_reg(1, 16, 4), pick_reg(1, 128, 32), pick_reg(1, 16, 4),
                         pick_reg(1, 4095, 256), pick_reg(1, 4096, 64), pick_reg(1, 128, 16),
                         pick_reg(1, 128, 4),
                         qkvhs_pkg::CFG_DATA_W'($urandom_range(20'hFFFFF)));
            for (k = 0; k < UNITS_PER_SEGMENT; k++)
                push_unit(pick_offset());
            drain_units();
        end

        $display("covered %0d work units, %0d tiles checked, %0d register settings",
                 sb.units_planned, sb.tiles_checked, settings_used);
        $display("idle mixes: none, sender 61%%, receiver 61%%, both 22%%; mismatches %0d",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
